// ===== sv/sse_pkg.sv =====
// ---------------------------------------------------------------------------
// sse_pkg: shared types for the event stream parser
// Transaction payloads, result kinds and queue sizing.
// ---------------------------------------------------------------------------
package sse_pkg;

	typedef enum logic [2:0] {
		KIND_DATA_BYTE   = 3'd0,
		KIND_EVENT_BYTE  = 3'd1,
		KIND_ID_BYTE     = 3'd2,
		KIND_EVENT_BEGIN = 3'd3,
		KIND_ID_BEGIN    = 3'd4,
		KIND_DISPATCH    = 3'd5,
		KIND_ERROR       = 3'd6
	} sse_kind_t;

	// input transaction
	typedef struct packed {
		logic       op;
		logic [7:0] byte_value;
	} sse_in_t;

	// output transaction
	typedef struct packed {
		sse_kind_t  kind;
		logic [7:0] out_byte;
		logic       last;
	} sse_out_t;

	// one result as produced by the front end
	typedef struct packed {
		sse_kind_t  kind;
		logic [7:0] data;
	} sse_res_t;

	// queue entry: all results of one input transaction
	typedef struct packed {
		logic     two;
		sse_res_t r0;
		sse_res_t r1;
	} sse_entry_t;

	// queue depth, power of two
	localparam int SSE_QAW    = 2;
	localparam int SSE_QDEPTH = 1 << SSE_QAW;

endpackage

// ===== sv/sse_front.sv =====
// ---------------------------------------------------------------------------
// sse_front: line and field classifier
// Accepts stream transactions, tracks the line state and forms up to two
// results per transaction, pushed as one queue entry.
// ---------------------------------------------------------------------------
module sse_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  sse_pkg::sse_in_t item,
	input  logic             q_full,
	output logic             q_push,
	output sse_pkg::sse_entry_t q_entry
);
	import sse_pkg::*;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_NAME   = 3'd1,
		PH_AFTER  = 3'd2,
		PH_VALUE  = 3'd3,
		PH_IGNORE = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		FLD_NONE  = 2'd0,
		FLD_DATA  = 2'd1,
		FLD_EVENT = 2'd2,
		FLD_ID    = 2'd3
	} field_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] prog;
		field_t     field;
		logic       cr;
		logic       pend;
		logic       dne;
		logic       fin;
	} state_t;

	typedef struct packed {
		logic     vld;
		sse_res_t res;
	} emit_t;

	typedef struct packed {
		state_t st;
		emit_t  em;
	} step_t;

	function automatic logic [2:0] name_len(field_t f);
		unique case (f)
			FLD_DATA:  name_len = 3'd4;
			FLD_EVENT: name_len = 3'd5;
			FLD_ID:    name_len = 3'd2;
			default:   name_len = 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] name_char(field_t f, logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		unique case (f)
			FLD_DATA: begin
				case (idx)
					3'd0: c = "d";
					3'd1: c = "a";
					3'd2: c = "t";
					3'd3: c = "a";
					default: c = 8'h00;
				endcase
			end
			FLD_EVENT: begin
				case (idx)
					3'd0: c = "e";
					3'd1: c = "v";
					3'd2: c = "e";
					3'd3: c = "n";
					3'd4: c = "t";
					default: c = 8'h00;
				endcase
			end
			FLD_ID: begin
				case (idx)
					3'd0: c = "i";
					3'd1: c = "d";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic emit_t mk(sse_kind_t k, logic [7:0] d);
		emit_t e;
		e.vld      = 1'b1;
		e.res.kind = k;
		e.res.data = d;
		return e;
	endfunction

	// field name complete: mark pending, emit join LF or begin marker
	function automatic step_t name_done(state_t s);
		step_t t;
		t.st      = s;
		t.em      = '0;
		t.st.pend = 1'b1;
		unique case (s.field)
			FLD_DATA:  if (s.dne) t.em = mk(KIND_DATA_BYTE, CH_LF);
			FLD_EVENT: t.em = mk(KIND_EVENT_BEGIN, 8'h00);
			FLD_ID:    t.em = mk(KIND_ID_BEGIN, 8'h00);
			default:   t.em = '0;
		endcase
		return t;
	endfunction

	function automatic step_t dispatch(state_t s);
		step_t t;
		t.st      = s;
		t.em      = '0;
		if (s.pend) t.em = mk(KIND_DISPATCH, 8'h00);
		t.st.pend = 1'b0;
		t.st.dne  = 1'b0;
		return t;
	endfunction

	function automatic step_t value_byte(state_t s, logic [7:0] b);
		step_t t;
		t.st = s;
		t.em = '0;
		if (s.field != FLD_NONE) begin
			t.em = mk(sse_kind_t'({1'b0, 2'(s.field - 2'd1)}), b);
			if (s.field == FLD_DATA) t.st.dne = 1'b1;
		end
		return t;
	endfunction

	function automatic step_t line_byte(state_t s, logic [7:0] b);
		step_t t;
		field_t f;
		t.st = s;
		t.em = '0;
		f    = FLD_NONE;
		unique case (s.phase)
			PH_START: begin
				if (b == CH_COLON) begin
					t.st.phase = PH_IGNORE;
				end else begin
					if (b == "d")      f = FLD_DATA;
					else if (b == "e") f = FLD_EVENT;
					else if (b == "i") f = FLD_ID;
					t.st.field = f;
					t.st.prog  = 3'd1;
					t.st.phase = (f == FLD_NONE) ? PH_IGNORE : PH_NAME;
				end
			end
			PH_NAME: begin
				if (s.field == FLD_NONE) begin
					t.st.phase = PH_IGNORE;
				end else if (b == CH_COLON) begin
					if (s.prog == name_len(s.field)) begin
						t = name_done(s);
						t.st.phase = PH_AFTER;
					end else begin
						t.st.phase = PH_IGNORE;
					end
				end else if (s.prog < name_len(s.field) &&
				             b == name_char(s.field, s.prog)) begin
					t.st.prog = s.prog + 3'd1;
				end else begin
					t.st.phase = PH_IGNORE;
				end
			end
			PH_AFTER: begin
				// skip a single space right after the colon
				t.st.phase = PH_VALUE;
				if (b != CH_SPACE) t = value_byte(t.st, b);
			end
			PH_VALUE: t = value_byte(s, b);
			default:  t = t;
		endcase
		return t;
	endfunction

	function automatic step_t line_end(state_t s, logic at_finish);
		step_t t;
		t.st = s;
		t.em = '0;
		if (s.phase == PH_START) begin
			if (!at_finish) t = dispatch(s);
		end else if (s.phase == PH_NAME && s.field != FLD_NONE &&
		             s.prog == name_len(s.field)) begin
			t = name_done(s);
		end
		t.st.phase = PH_START;
		t.st.prog  = 3'd0;
		t.st.field = FLD_NONE;
		return t;
	endfunction

	state_t state_q;
	state_t state_d;
	emit_t  e0;
	emit_t  e1;
	step_t  t0;
	step_t  t1;
	logic   accept;

	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;

	always_comb begin
		state_d = state_q;
		t0      = '0;
		t1      = '0;
		e0      = '0;
		e1      = '0;
		if (state_q.fin) begin
			e0 = mk(KIND_ERROR, 8'h00);
		end else if (item.op) begin
			state_d.cr  = 1'b0;
			state_d.fin = 1'b1;
			t0      = line_end(state_d, 1'b1);
			t1      = dispatch(t0.st);
			e0      = t0.em;
			e1      = t1.em;
			state_d = t1.st;
		end else if (item.byte_value == CH_LF) begin
			state_d.cr = 1'b0;
			t0      = line_end(state_d, 1'b0);
			e0      = t0.em;
			state_d = t0.st;
		end else begin
			// release a held CR as an ordinary byte first
			if (state_d.cr) begin
				state_d.cr = 1'b0;
				t0      = line_byte(state_d, CH_CR);
				e0      = t0.em;
				state_d = t0.st;
			end
			if (item.byte_value == CH_CR) begin
				state_d.cr = 1'b1;
			end else begin
				t1      = line_byte(state_d, item.byte_value);
				e1      = t1.em;
				state_d = t1.st;
			end
		end
	end

	// pack the results in order
	always_comb begin
		q_entry = '0;
		if (e0.vld) begin
			q_entry.r0  = e0.res;
			q_entry.r1  = e1.res;
			q_entry.two = e1.vld;
		end else begin
			q_entry.r0  = e1.res;
		end
	end

	assign q_push = accept && (e0.vld || e1.vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/sse_queue.sv =====
// ---------------------------------------------------------------------------
// sse_queue: result entry queue
// Small register queue between the classifier and the output sequencer.
// ---------------------------------------------------------------------------
module sse_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sse_pkg::sse_entry_t wr_entry,
	output logic                full,
	input  logic                pop,
	output sse_pkg::sse_entry_t head,
	output logic                empty
);
	import sse_pkg::*;

	sse_entry_t           mem_q [SSE_QDEPTH];
	logic [SSE_QAW-1:0]   wr_ptr_q;
	logic [SSE_QAW-1:0]   rd_ptr_q;
	logic [SSE_QAW:0]     cnt_q;

	assign full  = (cnt_q == (SSE_QAW+1)'(SSE_QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/sse_back.sv =====
// ---------------------------------------------------------------------------
// sse_back: output sequencer
// Presents the results of the head queue entry one per transaction and
// marks the final one.
// ---------------------------------------------------------------------------
module sse_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sse_pkg::sse_entry_t head,
	input  logic                empty,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_ready,
	output sse_pkg::sse_out_t   result
);
	import sse_pkg::*;

	logic     sub_q;
	logic     take;
	sse_res_t cur;

	assign result_valid = !empty;
	assign take         = result_valid && result_ready;
	assign cur          = sub_q ? head.r1 : head.r0;
	assign pop          = take && (sub_q || !head.two);

	always_comb begin
		result.kind     = cur.kind;
		result.out_byte = cur.data;
		result.last     = sub_q || !head.two;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 1'b0;
		end else if (take) begin
			sub_q <= !sub_q && head.two;
		end
	end

endmodule

// ===== sv/sse_event_stream_parser_unit.sv =====
// ---------------------------------------------------------------------------
// sse_event_stream_parser_unit: server-sent events stream parser
// Splits a byte stream into lines, recognizes data, event and id fields
// and streams their values out tagged by field, with dispatch markers.
// ---------------------------------------------------------------------------
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+------------------------------
//  item     | item_valid / item_ready / item   | op, byte_value
//  result   | result_valid / result_ready /    | kind, out_byte, last
//           | result                           |
//
//  One input transaction per cycle while the queue is not full; the
//  classifier updates its line state in the cycle the transaction is taken.
//  Each input yields zero to two results; the output side drains one result
//  per cycle while result_ready is high, so a two-result input goes out in turn.
//  A four-entry queue between classifier and sequencer absorbs those bursts
//  and output stalls; item_ready drops only while the queue is full.
//  Reset clears the line state and empties the queue; no clearing pass.
// ---------------------------------------------------------------------------
module sse_event_stream_parser_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  sse_pkg::sse_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output sse_pkg::sse_out_t result
);
	import sse_pkg::*;

	// classifier to queue
	logic       q_push;
	logic       q_full;
	sse_entry_t q_entry;

	// queue to sequencer
	logic       q_pop;
	logic       q_empty;
	sse_entry_t q_head;

	// front: accept, classify, form the results of each transaction
	sse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	// hold result entries until the output side takes them
	sse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_entry),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// back: advance through the head entry one result at a time
	sse_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.empty        (q_empty),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== sv/sse_checker.sv =====
// ---------------------------------------------------------------------------
// sse_checker: port-level checks for the parser
// Watches the result channel for payload consistency over time and the
// input stall against pending output.
// ---------------------------------------------------------------------------
module sse_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input sse_pkg::sse_out_t result
);
	import sse_pkg::*;

	// stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// dispatch and error always close the results of their input
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind == KIND_DISPATCH || result.kind == KIND_ERROR)
		|-> result.last)
		else $error("dispatch or error not marked last");

	// markers carry no byte
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind == KIND_EVENT_BEGIN || result.kind == KIND_ID_BEGIN ||
		result.kind == KIND_DISPATCH || result.kind == KIND_ERROR)
		|-> result.out_byte == 8'h00)
		else $error("marker result with nonzero byte");

	// a non-final result is followed by the rest of its group
	a_group: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.last |=> result_valid)
		else $error("result group broken");

	// input stalls only while results are waiting on the output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid)
		else $error("input stalled with no pending result");

endmodule

bind sse_event_stream_parser_unit sse_checker u_sse_checker (.*);
